// ----- sv/per_process_syscall_sequence_matcher_macros.svh -----
// Assertion macros used by the checker file of the syscall sequence matcher.
`ifndef PER_PROCESS_SYSCALL_SEQUENCE_MATCHER_MACROS_SVH
`define PER_PROCESS_SYSCALL_SEQUENCE_MATCHER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PPSSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PPSSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- sv/ppssm_pkg.sv -----
// Types and constants shared by the syscall sequence matcher modules.
package ppssm_pkg;

   localparam int PROC_COUNT    = 16;
   localparam int HISTORY_DEPTH = 32;
   localparam int SIG_MAX_LEN   = 4;
   localparam int SIG_COUNT     = 2;
   localparam int CODE_WIDTH    = 8;

   localparam int PID_W       = 4;
   localparam int SYSCALL_W   = 8;
   localparam int SIG_CODES_W = 32;
   localparam int SIG_LEN_W   = 3;
   localparam int SKIP_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int PROC_IDX_W  = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_ONE_CODES  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_ONE_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_TWO_CODES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_TWO_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_CODE_ONE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_CODE_TWO  = 3'd5;
   // Distance between the index of one signature and the next.
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_STRIDE     =
      CSR_SIG_TWO_CODES - CSR_SIG_ONE_CODES;

   typedef struct packed {
      logic [PID_W-1:0]     proc_id;
      logic [SYSCALL_W-1:0] syscall_code;
   } req_word_type;

   typedef struct packed {
      logic [PID_W-1:0] flagged_proc;
      logic             recorded;
      logic             detected;
   } rsp_word_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // Classified event as it waits between front and back.
   typedef struct packed {
      logic [PID_W-1:0]      pid;
      logic [CODE_WIDTH-1:0] code;
      logic                  recorded;
   } queue_word_type;

   // Newest codes of one process; element 0 is the newest.
   typedef logic [SIG_MAX_LEN-1:0][CODE_WIDTH-1:0] window_type;

endpackage

// ----- sv/ppssm_front.sv -----
// Front end: accepts syscall words and marks those that carry a skip code.
module ppssm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  ppssm_pkg::csr_write_type csr,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ppssm_pkg::req_word_type  req_word,
   output logic                    q_valid,
   input  logic                    q_ready,
   output ppssm_pkg::queue_word_type q_word
);
   import ppssm_pkg::*;

   logic [SKIP_W-1:0] skip_one_ff, skip_one_in;
   logic [SKIP_W-1:0] skip_two_ff, skip_two_in;
   logic              skipped;

   // Skip code registers.
   always_comb begin
      skip_one_in = skip_one_ff;
      skip_two_in = skip_two_ff;
      if (csr.valid && csr.index == CSR_SKIP_CODE_ONE) begin
         skip_one_in = csr.data[SKIP_W-1:0];
      end
      if (csr.valid && csr.index == CSR_SKIP_CODE_TWO) begin
         skip_two_in = csr.data[SKIP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_one_ff <= '0;
         skip_two_ff <= '0;
      end else begin
         skip_one_ff <= skip_one_in;
         skip_two_ff <= skip_two_in;
      end
   end

   // Classify the word and hand it to the queue.
   always_comb begin
      skipped = (req_word.syscall_code == skip_one_ff) ||
                (req_word.syscall_code == skip_two_ff);
      q_word.pid      = req_word.proc_id;
      q_word.code     = CODE_WIDTH'(req_word.syscall_code);
      q_word.recorded = !skipped;
      q_valid         = req_valid;
      req_ready       = q_ready;
   end

endmodule

// ----- sv/ppssm_fifo.sv -----
// Short queue that decouples the front end from the history back end.
module ppssm_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ppssm_pkg::queue_word_type in_word,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ppssm_pkg::queue_word_type out_word
);
   import ppssm_pkg::*;

   queue_word_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;
   logic                  push;
   logic                  pop;

   always_comb begin
      in_ready  = (count_ff != QCOUNT_W'(QUEUE_DEPTH));
      out_valid = (count_ff != '0);
      out_word  = slot_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

// ----- sv/ppssm_back.sv -----
// Back end: updates the history window of a process and matches signatures.
module ppssm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ppssm_pkg::csr_write_type  csr,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  ppssm_pkg::queue_word_type q_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ppssm_pkg::rsp_word_type   rsp_word
);
   import ppssm_pkg::*;

   logic [SIG_CODES_W-1:0] sig_codes_ff [SIG_COUNT];
   logic [SIG_CODES_W-1:0] sig_codes_in [SIG_COUNT];
   logic [SIG_LEN_W-1:0]   sig_len_ff   [SIG_COUNT];
   logic [SIG_LEN_W-1:0]   sig_len_in   [SIG_COUNT];
   window_type             history_ff   [PROC_COUNT];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [PROC_IDX_W-1:0]  proc_idx;
   window_type             row_old;
   window_type             row_new;
   logic                   sig_ok;
   logic                   hit;
   logic                   pop;

   // Signature registers; signature s sits one stride above signature s-1.
   always_comb begin
      for (int s = 0; s < SIG_COUNT; s++) begin
         sig_codes_in[s] = sig_codes_ff[s];
         sig_len_in[s]   = sig_len_ff[s];
         if (csr.valid &&
             csr.index == CSR_SIG_ONE_CODES + CSR_INDEX_W'(s) * CSR_SIG_STRIDE) begin
            sig_codes_in[s] = csr.data[SIG_CODES_W-1:0];
         end
         if (csr.valid &&
             csr.index == CSR_SIG_ONE_LENGTH + CSR_INDEX_W'(s) * CSR_SIG_STRIDE) begin
            sig_len_in[s] = csr.data[SIG_LEN_W-1:0];
         end
      end
   end

   // Shift the new code into the window and compare its newest entries.
   always_comb begin
      proc_idx   = PROC_IDX_W'(q_word.pid % PROC_COUNT);
      row_old    = history_ff[proc_idx];
      row_new[0] = q_word.code;
      for (int k = 1; k < SIG_MAX_LEN; k++) begin
         row_new[k] = row_old[k-1];
      end

      hit    = 1'b0;
      sig_ok = 1'b0;
      for (int s = 0; s < SIG_COUNT; s++) begin
         sig_ok = (sig_len_ff[s] != '0) &&
                  (int'(sig_len_ff[s]) <= SIG_MAX_LEN) &&
                  (int'(sig_len_ff[s]) <= HISTORY_DEPTH);
         // The entry k back from the newest meets signature code len-1-k.
         for (int k = 0; k < SIG_MAX_LEN; k++) begin
            for (int j = 0; j < SIG_MAX_LEN; j++) begin
               if ((int'(sig_len_ff[s]) - 1 - k == j) &&
                   (row_new[k] != CODE_WIDTH'(sig_codes_ff[s] >> (j * CODE_WIDTH)))) begin
                  sig_ok = 1'b0;
               end
            end
         end
         hit = hit | sig_ok;
      end

      pop          = q_valid && (!rsp_valid_ff || rsp_ready);
      q_ready      = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
      rsp_word_in  = rsp_word_ff;
      if (pop) begin
         rsp_word_in.flagged_proc = q_word.pid;
         rsp_word_in.recorded     = q_word.recorded;
         rsp_word_in.detected     = q_word.recorded && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SIG_COUNT; s++) begin
            sig_codes_ff[s] <= '0;
            sig_len_ff[s]   <= '0;
         end
         for (int p = 0; p < PROC_COUNT; p++) begin
            history_ff[p] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int s = 0; s < SIG_COUNT; s++) begin
            sig_codes_ff[s] <= sig_codes_in[s];
            sig_len_ff[s]   <= sig_len_in[s];
         end
         if (pop && q_word.recorded) begin
            history_ff[proc_idx] <= row_new;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- sv/per_process_syscall_sequence_matcher.sv -----
// Top level of the per-process syscall sequence matcher.
// Usage:
// - req_valid/req_ready carry one syscall word: a process id and a syscall code.
// - rsp_valid/rsp_ready return exactly one word per request, in order: the
//   echoed process id, whether the event was stored, and whether a stored
//   event makes the newest codes of that process end with an enabled signature.
// - csr_valid/csr_ready write one configuration register per handshake;
//   csr_ready is always high and writes to unknown indexes are dropped.
//   Write configuration only while no request is in flight.
// Flow: a request accepted at one clock edge is written into the queue and
// then into the response register before it can be taken on the response
// channel. One word per cycle is sustained while the receiver does not stall;
// the rate is set by the back end, which reads, shifts and writes one history
// window row for each word. A two-word queue between the front end and the
// back end lets the front keep accepting while a result waits in the
// response register. When the receiver stalls the response holds; once the
// queue fills, req_ready drops.
// Reset clears all configuration registers and every process history at once,
// so requests are taken as soon as reset is released.
module per_process_syscall_sequence_matcher (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  ppssm_pkg::req_word_type                  req_word,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output ppssm_pkg::rsp_word_type                  rsp_word,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [ppssm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ppssm_pkg::CSR_DATA_W-1:0]         csr_data
);
   import ppssm_pkg::*;

   csr_write_type  csr;
   logic           front_valid;
   logic           front_ready;
   queue_word_type front_word;
   logic           back_valid;
   logic           back_ready;
   queue_word_type back_word;

   // Configuration writes are always taken.
   always_comb begin
      csr_ready = 1'b1;
      csr.valid = csr_valid;
      csr.index = csr_index;
      csr.data  = csr_data;
   end

   ppssm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_valid   (front_valid),
      .q_ready   (front_ready),
      .q_word    (front_word)
   );

   ppssm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_word  (back_word)
   );

   ppssm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .q_valid   (back_valid),
      .q_ready   (back_ready),
      .q_word    (back_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- sv/ppssm_checker.sv -----
// Port-level assertions for the syscall sequence matcher, bound to its top level.
`include "per_process_syscall_sequence_matcher_macros.svh"

module ppssm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input ppssm_pkg::rsp_word_type rsp_word,
   input logic                    csr_ready
);
   import ppssm_pkg::*;

   // A stalled response keeps its word.
   `PPSSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled response changed")

   // A skipped event is never flagged as detected.
   `PPSSM_ASSERT_NOW(a_skip_no_detect, clock, reset, rsp_valid && !rsp_word.recorded, !rsp_word.detected, "detected set on a skipped event")

   // Reset empties the response register.
   `PPSSM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid right after reset")

   // A request taken while no response waits is followed by a valid response.
   `PPSSM_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready && !rsp_valid && csr_ready, ##1 rsp_valid, "accepted request produced no response")

endmodule

bind per_process_syscall_sequence_matcher ppssm_checker u_ppssm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word),
   .csr_ready (csr_ready)
);

// ----- verif/tb.sv -----
// Testbench for the per-process syscall sequence matcher: directed and random events.
`timescale 1ns / 100ps

module tb;
   import ppssm_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_EVENTS   = 200;
   localparam int PAUSE_INTERVAL = 50;
   localparam int RING_W         = $clog2(HISTORY_DEPTH);
   localparam int SIG_ONE        = 0;
   localparam int SIG_TWO        = 1;
   localparam int SKIP_COUNT     = 2;

   // Indexes past the register list; writes to them must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HIGH = 3'd7;

   // Keeps its own copy of settings and histories and checks each verdict in order.
   class syscall_verdict_board;
      logic [SIG_CODES_W-1:0] sig_codes [SIG_COUNT];
      logic [SIG_LEN_W-1:0]   sig_len   [SIG_COUNT];
      logic [SKIP_W-1:0]      skip_code [SKIP_COUNT];
      logic [CODE_WIDTH-1:0]  history   [PROC_COUNT][HISTORY_DEPTH];
      logic [RING_W-1:0]      ring_pos  [PROC_COUNT];
      rsp_word_type           awaited_verdicts [$];
      int                     error_count;

      function new();
         for (int s = 0; s < SIG_COUNT; s++) begin
            sig_codes[s] = '0;
            sig_len[s]   = '0;
         end
         for (int k = 0; k < SKIP_COUNT; k++) begin
            skip_code[k] = '0;
         end
         for (int p = 0; p < PROC_COUNT; p++) begin
            ring_pos[p] = '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
               history[p][k] = '0;
            end
         end
         error_count = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_SIG_ONE_CODES:  sig_codes[SIG_ONE] = data[SIG_CODES_W-1:0];
            CSR_SIG_ONE_LENGTH: sig_len[SIG_ONE]   = data[SIG_LEN_W-1:0];
            CSR_SIG_TWO_CODES:  sig_codes[SIG_TWO] = data[SIG_CODES_W-1:0];
            CSR_SIG_TWO_LENGTH: sig_len[SIG_TWO]   = data[SIG_LEN_W-1:0];
            CSR_SKIP_CODE_ONE:  skip_code[0]       = data[SKIP_W-1:0];
            CSR_SKIP_CODE_TWO:  skip_code[1]       = data[SKIP_W-1:0];
            default: ;
         endcase
      endfunction

      // True when the newest codes of the process equal the signature, newest last.
      function bit ends_with_signature(int p, int s);
         int len;
         int slot;
         len = int'(sig_len[s]);
         // Lengths of zero or past the window disable the signature.
         if (len == 0 || len > SIG_MAX_LEN || len > HISTORY_DEPTH) return 1'b0;
         slot = int'(ring_pos[p]);
         for (int i = len; i > 0; i--) begin
            if (history[p][slot] != sig_codes[s][(i-1)*CODE_WIDTH +: CODE_WIDTH])
               return 1'b0;
            slot = (slot + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
         end
         return 1'b1;
      endfunction

      // Updates the history of the event's process, unless its code is a skip code, and works out its verdict.
      function rsp_word_type judge_event(req_word_type w);
         rsp_word_type v;
         int p;
         v.flagged_proc = w.proc_id;
         v.recorded     = 1'b0;
         v.detected     = 1'b0;
         if (w.syscall_code == skip_code[0] || w.syscall_code == skip_code[1]) return v;
         p = int'(w.proc_id) % PROC_COUNT;
         ring_pos[p] = RING_W'((int'(ring_pos[p]) + 1) % HISTORY_DEPTH);
         history[p][ring_pos[p]] = w.syscall_code[CODE_WIDTH-1:0];
         v.recorded = 1'b1;
         for (int s = 0; s < SIG_COUNT; s++) begin
            if (ends_with_signature(p, s)) v.detected = 1'b1;
         end
         return v;
      endfunction

      function void note_event(req_word_type w);
         awaited_verdicts.push_back(judge_event(w));
      endfunction

      function void check_verdict(rsp_word_type got);
         rsp_word_type want;
         if (awaited_verdicts.size() == 0) begin
            $error("response word for proc %0d with no event outstanding", got.flagged_proc);
            error_count++;
            return;
         end
         want = awaited_verdicts.pop_front();
         if (got.flagged_proc !== want.flagged_proc) begin
            $error("flagged_proc: expected %0d, got %0d", want.flagged_proc, got.flagged_proc);
            error_count++;
         end
         if (got.recorded !== want.recorded) begin
            $error("recorded: expected %0b, got %0b", want.recorded, got.recorded);
            error_count++;
         end
         if (got.detected !== want.detected) begin
            $error("detected: expected %0b, got %0b", want.detected, got.detected);
            error_count++;
         end
      endfunction

      function int outstanding();
         return awaited_verdicts.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_word_type           req_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_word_type           rsp_word;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   syscall_verdict_board board;
   int send_gap_pct;
   int rsp_stall_pct;
   int quiet_cycles = 0;
   // Per process: which signature the well-formed traffic follows and how far it got.
   int chase_sig  [PROC_COUNT];
   int chase_step [PROC_COUNT];

   per_process_syscall_sequence_matcher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Outputs are sampled mid-cycle, where every signal has settled for the next edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_verdict(rsp_word);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic req_word_type make_event(int pid, logic [SYSCALL_W-1:0] code);
      req_word_type w;
      w.proc_id      = PID_W'(pid);
      w.syscall_code = code;
      return w;
   endfunction

   // Leaves valid high on return; the caller sends again or stops in the same step.
   task automatic send_event(input req_word_type w);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      board.note_event(w);
      @(posedge clock);
   endtask

   // Sender holds off until every outstanding verdict has come back.
   task automatic stop_and_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      board.write_register(index, data);
      @(posedge clock);
   endtask

   // Settings change only once the block is empty and has had time to settle.
   task automatic reconfigure(input logic [SIG_CODES_W-1:0] one_codes,
                              input logic [SIG_LEN_W-1:0] one_len,
                              input logic [SIG_CODES_W-1:0] two_codes,
                              input logic [SIG_LEN_W-1:0] two_len,
                              input logic [SKIP_W-1:0] skip_one,
                              input logic [SKIP_W-1:0] skip_two,
                              input bit poke_unmapped);
      stop_and_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_SIG_ONE_CODES, CSR_DATA_W'(one_codes));
      write_csr(CSR_SIG_ONE_LENGTH, CSR_DATA_W'(one_len));
      write_csr(CSR_SIG_TWO_CODES, CSR_DATA_W'(two_codes));
      write_csr(CSR_SIG_TWO_LENGTH, CSR_DATA_W'(two_len));
      write_csr(CSR_SKIP_CODE_ONE, CSR_DATA_W'(skip_one));
      write_csr(CSR_SKIP_CODE_TWO, CSR_DATA_W'(skip_two));
      if (poke_unmapped) begin
         write_csr(CSR_UNMAPPED_LOW, $urandom());
         write_csr(CSR_UNMAPPED_HIGH, $urandom());
      end
      csr_valid <= 1'b0;
      for (int p = 0; p < PROC_COUNT; p++) begin
         chase_sig[p]  = $urandom_range(SIG_COUNT - 1);
         chase_step[p] = 0;
      end
   endtask

   // Signature bytes mostly come from a small alphabet so that sequences overlap.
   function automatic logic [SIG_CODES_W-1:0] pick_signature_codes();
      logic [SIG_CODES_W-1:0] codes;
      for (int k = 0; k < SIG_MAX_LEN; k++) begin
         if ($urandom_range(99) < 80) begin
            codes[k*CODE_WIDTH +: CODE_WIDTH] = CODE_WIDTH'($urandom_range(1, 6));
         end else begin
            codes[k*CODE_WIDTH +: CODE_WIDTH] = CODE_WIDTH'($urandom_range(255));
         end
      end
      return codes;
   endfunction

   function automatic logic [SIG_LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return SIG_LEN_W'($urandom_range(SIG_MAX_LEN + 1, 7));
      return SIG_LEN_W'($urandom_range(1, SIG_MAX_LEN));
   endfunction

   function automatic logic [SKIP_W-1:0] pick_skip_code();
      int r;
      r = $urandom_range(99);
      if (r < 60) return SKIP_W'($urandom_range(255));
      if (r < 80) return SKIP_W'($urandom_range(1, 6));
      return ($urandom_range(1) == 0) ? '0 : '1;
   endfunction

   // Mostly signature codes in order per process, interleaved across processes,
   // with alphabet noise, fully random codes and skip codes mixed in.
   function automatic req_word_type random_event();
      req_word_type w;
      int p;
      int s;
      int len;
      int r;
      p = $urandom_range(PROC_COUNT - 1);
      r = $urandom_range(99);
      s = chase_sig[p];
      len = int'(board.sig_len[s]);
      w.proc_id = PID_W'(p);
      if (len == 0 || len > SIG_MAX_LEN) chase_sig[p] = $urandom_range(SIG_COUNT - 1);
      if (r < 60 && len >= 1 && len <= SIG_MAX_LEN) begin
         w.syscall_code = board.sig_codes[s][chase_step[p]*CODE_WIDTH +: CODE_WIDTH];
         chase_step[p]++;
         if (chase_step[p] >= len) begin
            chase_step[p] = 0;
            chase_sig[p]  = $urandom_range(SIG_COUNT - 1);
         end
      end else if (r < 80) begin
         w.syscall_code = SYSCALL_W'($urandom_range(1, 6));
      end else if (r < 92) begin
         w.syscall_code = SYSCALL_W'($urandom_range(255));
      end else begin
         w.syscall_code = board.skip_code[$urandom_range(SKIP_COUNT - 1)];
      end
      return w;
   endfunction

   task automatic run_directed();
      // Reset settings: both skip codes are zero and both signatures are off.
      send_event(make_event(0, 8'h00));
      send_event(make_event(15, 8'hFF));
      // Signature one is four zeros, so a fresh history matches on its first code.
      // Signature two is longer than the window allows and never matches.
      reconfigure(32'h0000_0000, 3'd4, 32'hFFFF_FFFF, 3'd7, 8'hFF, 8'h7E, 1'b1);
      send_event(make_event(3, 8'h00));
      send_event(make_event(3, 8'hFF));
      send_event(make_event(15, 8'h01));
      send_event(make_event(4, 8'h7E));
      // Full four-code sequence, a one-code signature, and interleaved processes.
      reconfigure(32'h0403_0201, 3'd4, 32'h0000_00FF, 3'd1, 8'h00, 8'h00, 1'b0);
      send_event(make_event(7, 8'h01));
      send_event(make_event(7, 8'h02));
      send_event(make_event(7, 8'h03));
      send_event(make_event(7, 8'h04));
      send_event(make_event(7, 8'hFF));
      send_event(make_event(8, 8'h00));
      send_event(make_event(9, 8'h01));
      send_event(make_event(9, 8'h02));
      send_event(make_event(10, 8'h03));
      send_event(make_event(9, 8'h03));
      send_event(make_event(9, 8'h04));
      // All-ones signature; repeated codes keep matching once the window is full.
      reconfigure(32'hFFFF_FFFF, 3'd4, 32'h0000_0000, 3'd5, 8'h80, 8'h7F, 1'b0);
      repeat (5) send_event(make_event(5, 8'hFF));
   endtask

   initial begin
      board = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      send_gap_pct  = 31;
      rsp_stall_pct = 70;
      for (int p = 0; p < PROC_COUNT; p++) begin
         chase_sig[p]  = 0;
         chase_step[p] = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         // Receiver-light first, then sender-light, then full rate both ways.
         if (ph == 3) begin
            send_gap_pct  = 70;
            rsp_stall_pct = 31;
         end else if (ph == 6) begin
            send_gap_pct  = 0;
            rsp_stall_pct = 0;
         end
         reconfigure(pick_signature_codes(), pick_length(), pick_signature_codes(),
                     pick_length(), pick_skip_code(), pick_skip_code(),
                     $urandom_range(3) == 0);
         for (int n = 0; n < PHASE_EVENTS; n++) begin
            if (ph == 1 && n > 0 && n % PAUSE_INTERVAL == 0) stop_and_drain();
            send_event(random_event());
         end
      end

      stop_and_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
